// ===== rtl/core/kdlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the key debounce and long-press unit.
// ----------------------------------------------------------------------------
package kdlp_pkg;

  // Widths of the item fields and configuration registers.
  localparam int unsigned KeysWidth     = 3;
  localparam int unsigned KindWidth     = 2;
  localparam int unsigned IntervalWidth = 8;
  localparam int unsigned HoldWidth     = 16;
  localparam int unsigned CfgIdxWidth   = 2;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned InDataWidth   = 8;
  localparam int unsigned OutDataWidth  = 8;

  // Number of keys wired up; key bits at or above this count are ignored.
  localparam int unsigned NumKeys = 3;
  localparam logic [KeysWidth-1:0] KeyMask =
      KeysWidth'(((32'd1 << NumKeys) - 32'd1) & ((32'd1 << KeysWidth) - 32'd1));

  // Register reset values.
  localparam logic [IntervalWidth-1:0] SampleIntervalRst = IntervalWidth'(10);
  localparam logic [HoldWidth-1:0]     LongPressRst      = HoldWidth'(100);

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgSampleInterval = 2'd0,
    CfgLongPress      = 2'd1
  } cfg_idx_e;

  // Debounce phases.
  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhConfirm = 2'd1,
    PhHeld    = 2'd2,
    PhLong    = 2'd3
  } phase_e;

  // Reported event kinds.
  typedef enum logic [KindWidth-1:0] {
    EvNone = 2'd0,
    EvDown = 2'd1,
    EvUp   = 2'd2,
    EvLong = 2'd3
  } event_kind_e;

  // One result item.
  typedef struct packed {
    event_kind_e           kind;
    logic [KeysWidth-1:0]  keys;
  } result_t;

endpackage

// ===== rtl/core/key_debounce_long_press_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_long_press_unit
// Debounces three keys sampled on a millisecond tick and reports down, up
// and long-press events, one result item per tick item.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ----------------------------
//  s_axis    in         s_axis_tvalid/tready       tdata[2:0] keys_pressed
//  m_axis    out        m_axis_tvalid/tready       tuser[1:0] event_kind,
//                                                  tdata[2:0] event_keys
//  cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// Each tick item is handled by the combinational phase machine: it computes
// the next state and the result from the current state and the incoming
// keys, and the result is registered in the output or the skid register.
// A new tick item can be accepted in every cycle while the skid register is
// empty; the sustained rate is one item per clock while the output drains.
// A skid register behind the output register lets one more item in while a
// result waits; input ready drops only when both hold a result.
// Reset clears the tick counter, phase, held keys, hold counter and both
// output slots, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module key_debounce_long_press_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Tick items.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Bits from low up: keys_pressed[2:0], zeros.
  input  logic [kdlp_pkg::InDataWidth-1:0]    s_axis_tdata_i,
  // Result items.
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // Bits from low up: event_keys[2:0], zeros.
  output logic [kdlp_pkg::OutDataWidth-1:0]   m_axis_tdata_o,
  // Bits from low up: event_kind[1:0].
  output logic [kdlp_pkg::KindWidth-1:0]      m_axis_tuser_o,
  // Configuration writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kdlp_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [kdlp_pkg::CfgDataWidth-1:0]   cfg_data_i
);
  import kdlp_pkg::*;

  // Configuration registers.
  logic [IntervalWidth-1:0] sample_interval_q;
  logic [HoldWidth-1:0]     long_press_q;

  // Debounce state.
  logic [IntervalWidth-1:0] tick_count_q, tick_count_d;
  phase_e                   phase_q, phase_d;
  logic [KeysWidth-1:0]     held_keys_q, held_keys_d;
  logic [HoldWidth-1:0]     hold_count_q, hold_count_d;

  // Output register and skid register.
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  result_t result;

  logic                     in_fire, out_fire, sample;
  logic [KeysWidth-1:0]     keys;
  logic [IntervalWidth-1:0] tick_inc;
  logic [HoldWidth-1:0]     hold_inc;

  // The configuration port never stalls; writes must only arrive while idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_interval_q <= SampleIntervalRst;
      long_press_q      <= LongPressRst;
    end else if (cfg_valid_i) begin
      // Writes to an index beyond the register list are dropped.
      if (cfg_index_i == CfgSampleInterval) begin
        sample_interval_q <= cfg_data_i[IntervalWidth-1:0];
      end else if (cfg_index_i == CfgLongPress) begin
        long_press_q <= cfg_data_i[HoldWidth-1:0];
      end
    end
  end

  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire        = out_valid_q && m_axis_tready_i;
  assign keys            = s_axis_tdata_i[KeysWidth-1:0] & KeyMask;

  // Tick counter saturates; a sample is taken once it reaches the interval.
  // An interval of zero, or one lowered below the count, samples at once.
  assign tick_inc = (tick_count_q != '1) ? tick_count_q + IntervalWidth'(1) : tick_count_q;
  assign sample   = (tick_inc >= sample_interval_q);
  assign hold_inc = (hold_count_q != '1) ? hold_count_q + HoldWidth'(1) : hold_count_q;

  // Phase machine: next state and result item for the current tick.
  always_comb begin
    tick_count_d = sample ? '0 : tick_inc;
    phase_d      = phase_q;
    held_keys_d  = held_keys_q;
    hold_count_d = hold_count_q;
    result.kind  = EvNone;
    result.keys  = '0;
    if (sample) begin
      unique case (phase_q)
        PhIdle: begin
          // Capture any nonzero combination for confirmation.
          if (keys != '0) begin
            held_keys_d = keys;
            phase_d     = PhConfirm;
          end
        end
        PhConfirm: begin
          if (keys == held_keys_q) begin
            phase_d     = PhHeld;
            result.kind = EvDown;
            result.keys = held_keys_q;
          end else begin
            phase_d = PhIdle;
          end
        end
        PhHeld: begin
          if (keys != held_keys_q) begin
            phase_d      = PhIdle;
            hold_count_d = '0;
            result.kind  = EvUp;
            result.keys  = held_keys_q;
          end else if (hold_inc >= long_press_q) begin
            hold_count_d = '0;
            phase_d      = PhLong;
            result.kind  = EvLong;
            result.keys  = keys;
          end else begin
            hold_count_d = hold_inc;
          end
        end
        PhLong: begin
          // Wait silently for the combination to change.
          if (keys != held_keys_q) begin
            phase_d = PhIdle;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= '0;
      phase_q      <= PhIdle;
      held_keys_q  <= '0;
      hold_count_q <= '0;
    end else if (in_fire) begin
      tick_count_q <= tick_count_d;
      phase_q      <= phase_d;
      held_keys_q  <= held_keys_d;
      hold_count_q <= hold_count_d;
    end
  end

  // Output slot valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        // The skid slot refills the output; otherwise a new item may.
        out_valid_q  <= skid_valid_q || in_fire;
        skid_valid_q <= 1'b0;
      end else if (in_fire) begin
        if (!out_valid_q) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end
    end
  end

  // Output slot payloads.
  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (in_fire) begin
      if (!out_valid_q) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = OutDataWidth'(out_q.keys);

endmodule
